@@ design/dts_pkg.sv @@
// ----------------------------------------------------------------------------
// dts_pkg: shared types and constants of the deadline timer scheduler
// Request codes, status codes and the scan struct that moves between cells.
// ----------------------------------------------------------------------------
package dts_pkg;

  localparam int unsigned DefaultTimerSlots = 16;

  typedef enum logic [1:0] {
    REQ_CREATE = 2'd0,
    REQ_STOP   = 2'd1,
    REQ_AHEAD  = 2'd2,
    REQ_TICK   = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_NO_FREE    = 2'd1,
    ST_NOT_ACTIVE = 2'd2
  } status_e;

  // control state of the top level
  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_EXEC = 2'd1,
    S_RESP = 2'd2
  } state_e;

  // command applied to one slot cell
  typedef enum logic [1:0] {
    OP_NONE     = 2'd0,
    OP_ACTIVATE = 2'd1,
    OP_FREE     = 2'd2,
    OP_SET_DL   = 2'd3
  } cell_op_e;

  // running best of the tick scan, handed from cell to cell
  typedef struct packed {
    logic        found;
    logic [31:0] age;
  } scan_t;

endpackage

@@ design/deadline_timer_scheduler.sv @@
// ----------------------------------------------------------------------------
// deadline_timer_scheduler: fixed table of timer slots with a ms clock
// Create, stop, ahead-once and tick requests; one response per request.
// ----------------------------------------------------------------------------
// channel | dir | tdata (low bit up)                                 | tuser
// s_axis  | in  | req_type, slot_id, delay_ms, period_ms, elapsed_ms | -
// m_axis  | out | status, result_slot, fired                         | -
//
// Flow: a request is taken in idle; the tick search then moves one cell
// per cycle along the slot row (registered between cells), and execute
// waits until the last cell's output is valid before the response is
// shown. A new request is taken only once the response is accepted; the
// cell chain length sets the time per request. Reset clears all active
// bits and the clock; periods are written only by create, deadlines by
// create, ahead and tick. A stalled response holds the block in S_RESP.
// ----------------------------------------------------------------------------
module deadline_timer_scheduler #(
  parameter int unsigned TIMER_SLOTS = dts_pkg::DefaultTimerSlots
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // req_type[1:0] slot_id[5:2] delay_ms[36:6] period_ms[67:37] elapsed_ms[75:68]
  input  logic [79:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // status[1:0] result_slot[5:2] fired[6]
  output logic [7:0]  m_axis_tdata
);
  import dts_pkg::*;

  localparam int unsigned IW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam int unsigned CW = $clog2(TIMER_SLOTS + 1);

  state_e state_q, state_d;

  logic [79:0]   req_q;
  logic [31:0]   now_q, now_d;
  logic [7:0]    resp_q, resp_d;
  logic [CW-1:0] cnt_q, cnt_d;   // execute cycles, lets the scan settle

  logic [1:0]  rtype;
  logic [3:0]  sid;
  logic [30:0] delay, period;
  logic [7:0]  elapsed;
  assign rtype   = req_q[1:0];
  assign sid     = req_q[5:2];
  assign delay   = req_q[36:6];
  assign period  = req_q[67:37];
  assign elapsed = req_q[75:68];

  scan_t       chain [TIMER_SLOTS+1];
  logic [TIMER_SLOTS-1:0] take, act, upd;
  logic [31:0] dl   [TIMER_SLOTS];
  logic [30:0] per  [TIMER_SLOTS];
  cell_op_e    op   [TIMER_SLOTS];
  logic [31:0] wdl  [TIMER_SLOTS];
  logic [31:0] scan_now;
  logic [31:0] cand;

  // tick compares against the advanced clock
  assign scan_now = (rtype == REQ_TICK) ? now_q + {24'd0, elapsed} : now_q;
  assign cand     = now_q + {1'b0, delay};
  assign chain[0] = '0;

  // free slot search and best pick: one-hot lowest / last taker in chain
  logic [TIMER_SLOTS-1:0] freeh, best;
  always_comb begin
    freeh = '0;
    best  = '0;
    for (int i = TIMER_SLOTS - 1; i >= 0; i--) begin
      if (!act[i]) freeh = TIMER_SLOTS'(1) << i;
    end
    for (int i = 0; i < TIMER_SLOTS; i++) begin
      if (take[i]) best = TIMER_SLOTS'(1) << i;
    end
  end

  // the scan settles cell by cell through the registers between cells; the
  // last cell's registered output is valid once scan_done is set
  logic          scan_done;
  logic          exec;
  logic          sid_ok;
  logic [IW-1:0] sidx;
  assign scan_done = (cnt_q == CW'(TIMER_SLOTS));
  assign exec      = (state_q == S_EXEC) && scan_done;
  assign sidx      = IW'(sid);
  assign sid_ok    = ({28'd0, sid} < 32'(TIMER_SLOTS)) && act[sidx];

  genvar g;
  generate
    for (g = 0; g < TIMER_SLOTS; g++) begin : g_cell
      always_comb begin
        upd[g] = 1'b0;
        op[g]  = OP_NONE;
        wdl[g] = cand;
        unique case (rtype)
          REQ_CREATE: begin
            upd[g] = exec && freeh[g];
            op[g]  = OP_ACTIVATE;
          end
          REQ_STOP: begin
            upd[g] = exec && sid_ok && (sidx == IW'(g));
            op[g]  = OP_FREE;
          end
          REQ_AHEAD: begin
            upd[g] = exec && sid_ok && (sidx == IW'(g)) && ((cand - dl[g]) >> 31 == 32'd1);
            op[g]  = OP_SET_DL;
          end
          default: begin
            upd[g] = exec && best[g];
            op[g]  = (per[g] != '0) ? OP_SET_DL : OP_FREE;
            wdl[g] = scan_now + {1'b0, per[g]};
          end
        endcase
      end
      dts_cell u_cell (
        .clk_i, .rst_ni,
        .upd_i(upd[g]), .op_i(op[g]), .dl_i(wdl[g]), .per_i(period),
        .per_we_i(rtype == REQ_CREATE), .now_i(scan_now),
        .scan_i(chain[g]), .scan_o(chain[g+1]), .take_o(take[g]),
        .active_o(act[g]), .dl_o(dl[g]), .per_o(per[g])
      );
    end
  endgenerate

  logic [3:0] fslot, bslot;
  always_comb begin
    fslot = '0;
    bslot = '0;
    for (int i = 0; i < TIMER_SLOTS; i++) begin
      if (freeh[i]) fslot = 4'(i);
      if (best[i])  bslot = 4'(i);
    end
  end

  always_comb begin
    state_d = state_q;
    now_d   = now_q;
    resp_d  = resp_q;
    cnt_d   = '0;
    unique case (state_q)
      S_IDLE: if (s_axis_tvalid) state_d = S_EXEC;
      S_EXEC: begin
        if (!scan_done) begin
          cnt_d = cnt_q + CW'(1);
        end else begin
          state_d = S_RESP;
          unique case (rtype)
            REQ_CREATE: resp_d = (freeh != '0) ? {1'b0, 1'b0, fslot, ST_OK}
                                               : {2'b0, 4'd0, ST_NO_FREE};
            REQ_STOP, REQ_AHEAD:
              resp_d = sid_ok ? {2'b0, sid, ST_OK} : {2'b0, sid, ST_NOT_ACTIVE};
            default: begin
              now_d  = scan_now;
              resp_d = {1'b0, chain[TIMER_SLOTS].found, bslot, ST_OK};
            end
          endcase
        end
      end
      default: if (m_axis_tready) state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      now_q   <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      now_q   <= now_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) req_q <= s_axis_tdata;
    resp_q <= resp_d;
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = (state_q == S_RESP);
  assign m_axis_tdata  = resp_q;
endmodule

@@ design/dts_cell.sv @@
// ----------------------------------------------------------------------------
// dts_cell: one timer slot
// Holds active bit, deadline and period; takes part in the search chain.
// ----------------------------------------------------------------------------
module dts_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                upd_i,       // apply a command this cycle
  input  dts_pkg::cell_op_e   op_i,
  input  logic [31:0]         dl_i,
  input  logic [30:0]         per_i,
  input  logic                per_we_i,
  input  logic [31:0]         now_i,
  input  dts_pkg::scan_t      scan_i,      // best so far from lower slots
  output dts_pkg::scan_t      scan_o,      // registered, one cell per cycle
  output logic                take_o,      // this slot beats all lower slots
  output logic                active_o,
  output logic [31:0]         dl_o,
  output logic [30:0]         per_o
);
  import dts_pkg::*;

  logic        active_q, active_d;
  logic [31:0] dl_q;
  logic [30:0] per_q;
  logic [31:0] age;
  scan_t       scan_q, scan_d;

  assign age    = now_i - dl_q;
  assign take_o = active_q && !age[31] && (!scan_i.found || age > scan_i.age);
  always_comb begin
    scan_d = scan_i;
    if (take_o) begin
      scan_d.found = 1'b1;
      scan_d.age   = age;
    end
  end

  always_comb begin
    active_d = active_q;
    if (upd_i && op_i == OP_ACTIVATE) active_d = 1'b1;
    if (upd_i && op_i == OP_FREE) active_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      scan_q   <= '0;
    end else begin
      active_q <= active_d;
      scan_q   <= scan_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd_i && (op_i == OP_ACTIVATE || op_i == OP_SET_DL)) dl_q <= dl_i;
    if (upd_i && per_we_i) per_q <= per_i;
  end

  assign scan_o   = scan_q;
  assign active_o = active_q;
  assign dl_o     = dl_q;
  assign per_o    = per_q;
endmodule

@@ tb/sv/deadline_timer_scheduler_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deadline_timer_scheduler_tb: self-checking bench for the timer slot table
// Random and directed create / stop / ahead / tick requests go through a
// queue-fed driver. Each response is checked against an in-bench timer model.
// ----------------------------------------------------------------------------
module deadline_timer_scheduler_tb;
  import dts_pkg::*;

  localparam int unsigned NSLOTS = 16;
  localparam int unsigned IDLE_LIMIT = 4000;

  typedef struct packed {
    logic [3:0]  pad;
    logic [7:0]  elapsed;
    logic [30:0] period;
    logic [30:0] delay;
    logic [3:0]  slot;
    req_e        kind;
  } timer_req_t;

  typedef struct packed {
    logic       fired;
    logic [3:0] slot;
    status_e    status;
  } timer_rsp_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [79:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;

  deadline_timer_scheduler #(.TIMER_SLOTS(NSLOTS)) dut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // timer model state
  logic        mdl_active [NSLOTS];
  logic [31:0] mdl_deadline [NSLOTS];
  logic [30:0] mdl_period [NSLOTS];
  logic [31:0] mdl_now;

  timer_req_t pending_reqs[$];
  timer_rsp_t expected_rsps[$];
  int errors = 0;
  int idle_cycles = 0;
  int hold_off = 0;   // long receiver hold-off, in cycles
  int gap_cnt = 0;    // idle cycles before the next request
  bit stim_done = 0;
  logic in_taken = 1'b0;  // request accepted at the last rising edge

  function automatic timer_rsp_t predict_timer(timer_req_t r);
    timer_rsp_t rsp;
    logic [31:0] cand, age, best_age;
    int best;
    rsp = '{fired: 1'b0, slot: 4'd0, status: ST_OK};
    best = -1;
    best_age = '0;
    case (r.kind)
      REQ_CREATE: begin
        rsp.status = ST_NO_FREE;
        for (int i = 0; i < NSLOTS; i++) begin
          if (!mdl_active[i]) begin
            mdl_active[i] = 1'b1;
            mdl_deadline[i] = mdl_now + {1'b0, r.delay};
            mdl_period[i] = r.period;
            rsp.status = ST_OK;
            rsp.slot = 4'(i);
            break;
          end
        end
      end
      REQ_STOP, REQ_AHEAD: begin
        rsp.slot = r.slot;
        if (!mdl_active[r.slot]) begin
          rsp.status = ST_NOT_ACTIVE;
        end else if (r.kind == REQ_STOP) begin
          mdl_active[r.slot] = 1'b0;
        end else begin
          cand = mdl_now + {1'b0, r.delay};
          if (cand - mdl_deadline[r.slot] >= 32'h8000_0000) begin
            mdl_deadline[r.slot] = cand;
          end
        end
      end
      default: begin
        mdl_now = mdl_now + 32'(r.elapsed);
        for (int i = 0; i < NSLOTS; i++) begin
          age = mdl_now - mdl_deadline[i];
          if (mdl_active[i] && !age[31] && (best < 0 || age > best_age)) begin
            best = i;
            best_age = age;
          end
        end
        if (best >= 0) begin
          if (mdl_period[best] != '0) begin
            mdl_deadline[best] = mdl_now + {1'b0, mdl_period[best]};
          end else begin
            mdl_active[best] = 1'b0;
          end
          rsp.slot = 4'(best);
          rsp.fired = 1'b1;
        end
      end
    endcase
    return rsp;
  endfunction

  function automatic timer_req_t make_req(req_e k, int slot, logic [30:0] dly,
                                          logic [30:0] per, logic [7:0] el);
    timer_req_t r;
    r = '0;
    r.kind = k;
    r.slot = 4'(slot);
    r.delay = dly;
    r.period = per;
    r.elapsed = el;
    return r;
  endfunction

  // small delays mostly so ticks actually fire; sometimes full range
  function automatic logic [30:0] rand_ms();
    case ($urandom_range(0, 9))
      0: return 31'($urandom);
      1: return 31'h7FFF_FFFF - 31'($urandom_range(0, 300));
      default: return 31'($urandom_range(0, 600));
    endcase
  endfunction

  initial begin
    logic [7:0] el;
    // directed: empty ops, extremes, table full, ahead not earlier
    pending_reqs.push_back(make_req(REQ_TICK, 0, 31'd0, 31'd0, 8'd0));
    pending_reqs.push_back(make_req(REQ_STOP, 15, 31'd0, 31'd0, 8'd0));
    pending_reqs.push_back(make_req(REQ_AHEAD, 3, 31'd0, 31'd0, 8'd0));
    pending_reqs.push_back(make_req(REQ_CREATE, 0, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 8'd0));
    pending_reqs.push_back(make_req(REQ_CREATE, 0, 31'd10, 31'd0, 8'd0));
    pending_reqs.push_back(make_req(REQ_AHEAD, 0, 31'd5, 31'd0, 8'd0));
    pending_reqs.push_back(make_req(REQ_AHEAD, 1, 31'd50, 31'd0, 8'd0));
    pending_reqs.push_back(make_req(REQ_CREATE, 0, 31'd10, 31'd7, 8'd0));
    for (int i = 0; i < 15; i++) begin
      pending_reqs.push_back(make_req(REQ_CREATE, 0, 31'd255, 31'd1, 8'hFF));
    end
    pending_reqs.push_back(make_req(REQ_TICK, 0, 31'd0, 31'd0, 8'hFF));
    pending_reqs.push_back(make_req(REQ_STOP, 0, 31'd0, 31'd0, 8'd0));
    pending_reqs.push_back(make_req(REQ_TICK, 0, 31'd0, 31'd0, 8'hFF));
    for (int i = 0; i < 1750; i++) begin
      el = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 40));
      pending_reqs.push_back(make_req(req_e'($urandom_range(0, 3)),
                             int'($urandom_range(0, 15)), rand_ms(),
                             ($urandom_range(0, 2) == 0) ? 31'd0 : rand_ms(), el));
    end
    stim_done = 1;
  end

  // reset and model init
  initial begin
    for (int i = 0; i < NSLOTS; i++) mdl_active[i] = 1'b0;
    mdl_now = '0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
  end

  // driver: falling edge, random gap per request
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!s_axis_tvalid || in_taken) begin
        if (gap_cnt > 0) begin
          s_axis_tvalid <= 1'b0;
          gap_cnt <= gap_cnt - 1;
        end else if (stim_done && pending_reqs.size() > 0) begin
          s_axis_tdata <= 80'(pending_reqs.pop_front());
          s_axis_tvalid <= 1'b1;
          gap_cnt <= ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 8)) : 0;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver ready: long hold-off once, then random stalls
  initial begin
    int stall;
    @(posedge rst_ni);
    repeat (30) @(negedge clk_i);
    for (hold_off = 0; hold_off < 200; hold_off++) @(negedge clk_i);
    forever begin
      stall = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 8)) : 0;
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
      @(negedge clk_i);
    end
  end

  // monitor and watchdog
  always @(posedge clk_i) begin
    timer_rsp_t got, exp_rsp;
    if (rst_ni) begin
      in_taken <= s_axis_tvalid && s_axis_tready;
      if (s_axis_tvalid && s_axis_tready) begin
        expected_rsps.push_back(predict_timer(timer_req_t'(s_axis_tdata)));
      end
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = timer_rsp_t'(m_axis_tdata[6:0]);
        if (expected_rsps.size() == 0) begin
          $display("%0t: unexpected response %h", $realtime, m_axis_tdata);
          errors++;
        end else begin
          exp_rsp = expected_rsps.pop_front();
          if (got.status != exp_rsp.status) begin
            $display("%0t: status exp %0d got %0d", $realtime, exp_rsp.status, got.status);
            errors++;
          end
          if (got.slot != exp_rsp.slot) begin
            $display("%0t: slot exp %0d got %0d", $realtime, exp_rsp.slot, got.slot);
            errors++;
          end
          if (got.fired != exp_rsp.fired) begin
            $display("%0t: fired exp %0d got %0d", $realtime, exp_rsp.fired, got.fired);
            errors++;
          end
        end
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // end of run
  initial begin
    wait (stim_done);
    wait (pending_reqs.size() == 0);
    wait (expected_rsps.size() == 0 && !s_axis_tvalid);
    repeat (20) @(posedge clk_i);
    if (errors == 0 && expected_rsps.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
